// ----- design/sosbtn_pkg.sv -----
// sosbtn_pkg: shared types and constants for the button multi-click / long-press detector
// mode codes, configuration register indexes, reset defaults and the config struct
// no dependencies
`timescale 1ns / 1ps

package sosbtn_pkg;

    // fsm mode codes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_CLICK = 3'd1;
    localparam logic [2:0] MODE_CHECK = 3'd2;
    localparam logic [2:0] MODE_LONG  = 3'd3;
    localparam logic [2:0] MODE_STUCK = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_LONG     = 3'd1;
    localparam logic [2:0] REG_WINDOW   = 3'd2;
    localparam logic [2:0] REG_STUCK    = 3'd3;
    localparam logic [2:0] REG_CLICKS   = 3'd4;

    // configuration reset values
    localparam logic [15:0] DEBOUNCE_RST = 16'd50;
    localparam logic [15:0] LONG_RST     = 16'd2000;
    localparam logic [15:0] WINDOW_RST   = 16'd4000;
    localparam logic [15:0] STUCK_RST    = 16'd40000;
    localparam logic [2:0]  CLICKS_RST   = 3'd3;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] click_window_ms;
        logic [15:0] stuck_fault_ms;
        logic [2:0]  clicks_needed;
    } cfg_t;

endpackage

// ----- design/sosbtn_if.sv -----
// sosbtn_in_if / sosbtn_out_if: valid-ready channels for samples and results
// payload widths follow the fixed field widths
// no dependencies
`timescale 1ns / 1ps

interface sosbtn_in_if;
    logic        valid;
    logic        ready;
    logic        pressed;
    logic [31:0] now_ms;

    modport source (output valid, output pressed, output now_ms, input ready);
    modport sink (input valid, input pressed, input now_ms, output ready);
endinterface

interface sosbtn_out_if;
    logic       valid;
    logic       ready;
    logic       call_request;
    logic       stuck_fault;
    logic [2:0] mode;

    modport source (output valid, output call_request, output stuck_fault, output mode,
                    input ready);
    modport sink (input valid, input call_request, input stuck_fault, input mode,
                  output ready);
endinterface

// ----- design/sosbtn_step.sv -----
// sosbtn_step: next-state and result logic for one button sample
// pure combinational; uses sosbtn_pkg for mode codes and the config struct
`timescale 1ns / 1ps

module sosbtn_step #(
    parameter int TIME_BITS = 32
) (
    input  sosbtn_pkg::cfg_t         cfg,
    input  logic                     pressed,
    input  logic [TIME_BITS-1:0]     now,
    input  logic [2:0]               mode,
    input  logic [2:0]               press_count,
    input  logic                     count_active,
    input  logic [TIME_BITS-1:0]     window_start,
    input  logic [TIME_BITS-1:0]     press_start,
    output logic [2:0]               mode_next,
    output logic [2:0]               press_count_next,
    output logic                     count_active_next,
    output logic [TIME_BITS-1:0]     window_start_next,
    output logic [TIME_BITS-1:0]     press_start_next,
    output logic                     call
);

    logic [TIME_BITS-1:0] since_window;
    logic [TIME_BITS-1:0] since_press;
    logic [TIME_BITS-1:0] debounce_lim;
    logic [TIME_BITS-1:0] long_lim;
    logic [TIME_BITS-1:0] window_lim;
    logic [TIME_BITS-1:0] stuck_lim;

    // wrapping elapsed times and zero-extended thresholds
    assign since_window = now - window_start;
    assign since_press  = now - press_start;
    assign debounce_lim = TIME_BITS'(cfg.debounce_ms);
    assign long_lim     = TIME_BITS'(cfg.long_press_ms);
    assign window_lim   = TIME_BITS'(cfg.click_window_ms);
    assign stuck_lim    = TIME_BITS'(cfg.stuck_fault_ms);

    // mode transitions
    always_comb
    begin
        mode_next         = mode;
        press_count_next  = press_count;
        count_active_next = count_active;
        window_start_next = window_start;
        press_start_next  = press_start;
        call              = 1'b0;

        case (mode)
            sosbtn_pkg::MODE_CLICK:
            begin
                if (pressed)
                begin
                    if (since_press >= debounce_lim)
                    begin
                        if (press_count < cfg.clicks_needed)
                        begin
                            press_count_next = press_count + 3'd1;
                            mode_next        = sosbtn_pkg::MODE_CHECK;
                        end
                        else
                        begin
                            count_active_next = 1'b0;
                            press_count_next  = '0;
                            window_start_next = '0;
                            mode_next         = sosbtn_pkg::MODE_IDLE;
                            press_start_next  = '0;
                        end
                    end
                end
                else
                begin
                    count_active_next = 1'b0;
                    press_count_next  = '0;
                    window_start_next = '0;
                    mode_next         = sosbtn_pkg::MODE_IDLE;
                    press_start_next  = '0;
                end
            end
            sosbtn_pkg::MODE_CHECK:
            begin
                if (since_window <= window_lim)
                begin
                    if (count_active && (press_count >= cfg.clicks_needed))
                    begin
                        call              = 1'b1;
                        count_active_next = 1'b0;
                        press_count_next  = '0;
                        window_start_next = '0;
                        mode_next         = sosbtn_pkg::MODE_IDLE;
                        press_start_next  = '0;
                    end
                    else if (pressed)
                    begin
                        if (since_press >= long_lim)
                        begin
                            count_active_next = 1'b0;
                            press_count_next  = '0;
                            window_start_next = '0;
                            mode_next         = sosbtn_pkg::MODE_LONG;
                        end
                    end
                    else
                    begin
                        mode_next        = sosbtn_pkg::MODE_IDLE;
                        press_start_next = '0;
                    end
                end
                else
                begin
                    mode_next        = sosbtn_pkg::MODE_IDLE;
                    press_start_next = '0;
                end
            end
            sosbtn_pkg::MODE_LONG:
            begin
                if (pressed)
                begin
                    if (since_press >= stuck_lim)
                    begin
                        mode_next = sosbtn_pkg::MODE_STUCK;
                    end
                end
                else
                begin
                    call             = 1'b1;
                    mode_next        = sosbtn_pkg::MODE_IDLE;
                    press_start_next = '0;
                end
            end
            sosbtn_pkg::MODE_STUCK:
            begin
                if (!pressed)
                begin
                    mode_next        = sosbtn_pkg::MODE_IDLE;
                    press_start_next = '0;
                end
            end
            default:
            begin
                // idle, and any unused code
                if (pressed)
                begin
                    press_start_next = now;
                    if (!count_active)
                    begin
                        count_active_next = 1'b1;
                        press_count_next  = '0;
                        window_start_next = now;
                    end
                    else if (since_window > window_lim)
                    begin
                        press_count_next  = '0;
                        window_start_next = now;
                    end
                    mode_next = sosbtn_pkg::MODE_CLICK;
                end
                else if (count_active)
                begin
                    press_start_next = now;
                    if (since_window > window_lim)
                    begin
                        count_active_next = 1'b0;
                        press_count_next  = '0;
                        window_start_next = '0;
                    end
                end
            end
        endcase
    end

endmodule

// ----- design/sos_button_multiclick_longpress_top.sv -----
// Button multi-click / long-press detector with stuck-button fault.
// A sample is accepted into the input register and its result moves to the result
// register when the result side is free; throughput is one sample per cycle while
// results are taken, set by the single next-state pass between the two registers.
// Reset (rst_n low, asynchronous) clears the fsm state to idle with no window open
// and loads the configuration registers with their default values.
// depends on sosbtn_pkg, sosbtn_if and sosbtn_step
`timescale 1ns / 1ps

module sos_button_multiclick_longpress_top #(
    parameter int TIME_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sosbtn_in_if.sink            sample,
    sosbtn_out_if.source         result,
    input  logic                 wr_en,
    input  logic [2:0]           wr_index,
    input  logic [15:0]          wr_data
);

    sosbtn_pkg::cfg_t        cfg_reg;

    logic                    in_valid_reg;
    logic                    in_pressed_reg;
    logic [TIME_BITS-1:0]    in_now_reg;

    logic [2:0]              mode_reg;
    logic [2:0]              press_count_reg;
    logic                    count_active_reg;
    logic [TIME_BITS-1:0]    window_start_reg;
    logic [TIME_BITS-1:0]    press_start_reg;

    logic                    out_valid_reg;
    logic                    out_call_reg;
    logic                    out_stuck_reg;
    logic [2:0]              out_mode_reg;

    logic [2:0]              mode_next;
    logic [2:0]              press_count_next;
    logic                    count_active_next;
    logic [TIME_BITS-1:0]    window_start_next;
    logic [TIME_BITS-1:0]    press_start_next;
    logic                    call_next;

    logic                    out_free;
    logic                    advance;
    logic                    in_ready;

    // pipeline flow control
    assign out_free     = !out_valid_reg || result.ready;
    assign advance      = in_valid_reg && out_free;
    assign in_ready     = !in_valid_reg || out_free;
    assign sample.ready = in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= sosbtn_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ms   <= sosbtn_pkg::LONG_RST;
            cfg_reg.click_window_ms <= sosbtn_pkg::WINDOW_RST;
            cfg_reg.stuck_fault_ms  <= sosbtn_pkg::STUCK_RST;
            cfg_reg.clicks_needed   <= sosbtn_pkg::CLICKS_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                sosbtn_pkg::REG_DEBOUNCE: cfg_reg.debounce_ms     <= wr_data;
                sosbtn_pkg::REG_LONG:     cfg_reg.long_press_ms   <= wr_data;
                sosbtn_pkg::REG_WINDOW:   cfg_reg.click_window_ms <= wr_data;
                sosbtn_pkg::REG_STUCK:    cfg_reg.stuck_fault_ms  <= wr_data;
                sosbtn_pkg::REG_CLICKS:   cfg_reg.clicks_needed   <= wr_data[2:0];
                default:                  ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && sample.valid)
        begin
            in_pressed_reg <= sample.pressed;
            in_now_reg     <= sample.now_ms[TIME_BITS-1:0];
        end
    end

    // next-state logic
    sosbtn_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .cfg               (cfg_reg),
        .pressed           (in_pressed_reg),
        .now               (in_now_reg),
        .mode              (mode_reg),
        .press_count       (press_count_reg),
        .count_active      (count_active_reg),
        .window_start      (window_start_reg),
        .press_start       (press_start_reg),
        .mode_next         (mode_next),
        .press_count_next  (press_count_next),
        .count_active_next (count_active_next),
        .window_start_next (window_start_next),
        .press_start_next  (press_start_next),
        .call              (call_next)
    );

    // fsm state, updated as an item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= sosbtn_pkg::MODE_IDLE;
            press_count_reg  <= '0;
            count_active_reg <= 1'b0;
            window_start_reg <= '0;
            press_start_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg         <= mode_next;
            press_count_reg  <= press_count_next;
            count_active_reg <= count_active_next;
            window_start_reg <= window_start_next;
            press_start_reg  <= press_start_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_call_reg  <= call_next;
            out_stuck_reg <= (mode_next == sosbtn_pkg::MODE_STUCK);
            out_mode_reg  <= mode_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.call_request = out_call_reg;
    assign result.stuck_fault  = out_stuck_reg;
    assign result.mode         = out_mode_reg;

    // state moves only when an item advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(mode_reg) && $stable(press_count_reg)
                     && $stable(count_active_reg))
        else $error("fsm state changed without an item advancing");

    // input side stalls only when both stages are full and the result is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !result.ready)
        else $error("input stalled without a full pipeline");

    // no count survives a closed window
    a_count_window: assert property (@(posedge clk) disable iff (!rst_n)
        !count_active_reg |-> press_count_reg == 3'd0)
        else $error("press count nonzero with no window open");

    // releasing a long press issues a call and returns to idle
    a_long_release: assert property (@(posedge clk) disable iff (!rst_n)
        advance && mode_reg == sosbtn_pkg::MODE_LONG && !in_pressed_reg
        |=> out_call_reg && mode_reg == sosbtn_pkg::MODE_IDLE)
        else $error("long press release did not issue a call");

    // a call never coincides with the stuck state
    a_call_not_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_call_reg && out_stuck_reg))
        else $error("call issued while stuck");

endmodule

// ----- tb/sosbtn_call_checker.sv -----
// sosbtn_call_checker: watches the sample and result channels of the button detector,
// predicts every result from its own copy of the fsm and configuration and compares
// depends on sosbtn_pkg and sosbtn_if
`timescale 1ns / 1ps

module sosbtn_call_checker (
    input  logic        clk,
    input  logic        rst_n,
    sosbtn_in_if        sample,
    sosbtn_out_if       result,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data,
    output int unsigned fail_count,
    output int unsigned pending
);

    localparam logic [31:0] TIME_MASK = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       call;
        logic       stuck;
        logic [2:0] mode;
    } btn_result_t;

    // mirrored configuration and button state
    sosbtn_pkg::cfg_t cfg;
    logic [2:0]  btn_mode;
    logic [2:0]  click_count;
    logic        window_open;
    logic [31:0] window_t0;
    logic [31:0] press_t0;

    btn_result_t expected_q[$];
    int unsigned mismatches;

    // wrapping elapsed time
    function automatic logic [31:0] held_ms(input logic [31:0] now, input logic [31:0] since);
        return (now - since) & TIME_MASK;
    endfunction

    function automatic void close_window();
        window_open = 1'b0;
        click_count = '0;
        window_t0   = '0;
    endfunction

    function automatic void go_idle();
        btn_mode = sosbtn_pkg::MODE_IDLE;
        press_t0 = '0;
    endfunction

    // one sample through the click / long press fsm
    function automatic btn_result_t step_button(input logic pressed, input logic [31:0] now);
        btn_result_t r;
        logic        call;
        call = 1'b0;
        case (btn_mode)
            sosbtn_pkg::MODE_CLICK:
            begin
                if (pressed)
                begin
                    if (held_ms(now, press_t0) >= cfg.debounce_ms)
                    begin
                        if (click_count < cfg.clicks_needed)
                        begin
                            click_count = click_count + 3'd1;
                            btn_mode    = sosbtn_pkg::MODE_CHECK;
                        end
                        else
                        begin
                            close_window();
                            go_idle();
                        end
                    end
                end
                else
                begin
                    close_window();
                    go_idle();
                end
            end
            sosbtn_pkg::MODE_CHECK:
            begin
                if (held_ms(now, window_t0) <= cfg.click_window_ms)
                begin
                    if (window_open && click_count >= cfg.clicks_needed)
                    begin
                        call = 1'b1;
                        close_window();
                        go_idle();
                    end
                    else if (pressed)
                    begin
                        if (held_ms(now, press_t0) >= cfg.long_press_ms)
                        begin
                            close_window();
                            btn_mode = sosbtn_pkg::MODE_LONG;
                        end
                    end
                    else
                        go_idle();
                end
                else
                    go_idle();
            end
            sosbtn_pkg::MODE_LONG:
            begin
                if (pressed)
                begin
                    if (held_ms(now, press_t0) >= cfg.stuck_fault_ms)
                        btn_mode = sosbtn_pkg::MODE_STUCK;
                end
                else
                begin
                    call = 1'b1;
                    go_idle();
                end
            end
            sosbtn_pkg::MODE_STUCK:
            begin
                if (!pressed)
                    go_idle();
            end
            default:
            begin
                // idle: a press opens the window or restarts a lapsed one; a release closes a lapsed one
                if (pressed)
                begin
                    press_t0 = now;
                    if (!window_open)
                    begin
                        window_open = 1'b1;
                        click_count = '0;
                        window_t0   = now;
                    end
                    else if (held_ms(now, window_t0) > cfg.click_window_ms)
                    begin
                        click_count = '0;
                        window_t0   = now;
                    end
                    btn_mode = sosbtn_pkg::MODE_CLICK;
                end
                else if (window_open)
                begin
                    press_t0 = now;
                    if (held_ms(now, window_t0) > cfg.click_window_ms)
                        close_window();
                end
            end
        endcase
        r.call  = call;
        r.stuck = (btn_mode == sosbtn_pkg::MODE_STUCK);
        r.mode  = btn_mode;
        return r;
    endfunction

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        mismatches++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // predict on accepted samples, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        btn_result_t got;
        btn_result_t want;
        if (!rst_n)
        begin
            cfg.debounce_ms     = sosbtn_pkg::DEBOUNCE_RST;
            cfg.long_press_ms   = sosbtn_pkg::LONG_RST;
            cfg.click_window_ms = sosbtn_pkg::WINDOW_RST;
            cfg.stuck_fault_ms  = sosbtn_pkg::STUCK_RST;
            cfg.clicks_needed   = sosbtn_pkg::CLICKS_RST;
            btn_mode    = sosbtn_pkg::MODE_IDLE;
            click_count = '0;
            window_open = 1'b0;
            window_t0   = '0;
            press_t0    = '0;
            expected_q.delete();
            mismatches  = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    sosbtn_pkg::REG_DEBOUNCE: cfg.debounce_ms     = wr_data;
                    sosbtn_pkg::REG_LONG:     cfg.long_press_ms   = wr_data;
                    sosbtn_pkg::REG_WINDOW:   cfg.click_window_ms = wr_data;
                    sosbtn_pkg::REG_STUCK:    cfg.stuck_fault_ms  = wr_data;
                    sosbtn_pkg::REG_CLICKS:   cfg.clicks_needed   = wr_data[2:0];
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready)
                expected_q.push_back(step_button(sample.pressed, sample.now_ms));
            if (result.valid && result.ready)
            begin
                got.call  = result.call_request;
                got.stuck = result.stuck_fault;
                got.mode  = result.mode;
                if (expected_q.size() == 0)
                    report("result with nothing expected, mode", got.mode, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (got.call !== want.call)
                        report("call_request", got.call, want.call);
                    if (got.stuck !== want.stuck)
                        report("stuck_fault", got.stuck, want.stuck);
                    if (got.mode !== want.mode)
                        report("mode", got.mode, want.mode);
                end
            end
            fail_count <= mismatches;
            pending    <= expected_q.size();
        end
    end

endmodule

// ----- tb/sos_button_multiclick_longpress_top_tb.sv -----
// sos_button_multiclick_longpress_top_tb: drives button samples and configuration
// through several settings and gives the verdict from the checker's failure count
// depends on sosbtn_pkg, sosbtn_if, the detector top and sosbtn_call_checker
`timescale 1ns / 1ps

module sos_button_multiclick_longpress_top_tb;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 10000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [15:0] wr_data;

    sosbtn_in_if  in_ch ();
    sosbtn_out_if out_ch ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned items_sent;
    int unsigned quiet_cycles;
    int unsigned rx_stall;
    logic [31:0] clock_ms;
    logic        idle_on;
    logic        hold_req;
    logic        hold_done;

    sos_button_multiclick_longpress_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (in_ch),
        .result   (out_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    sosbtn_call_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (in_ch),
        .result     (out_ch),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic sosbtn_pkg::cfg_t make_cfg(input logic [15:0] deb,
                                                  input logic [15:0] lng,
                                                  input logic [15:0] win,
                                                  input logic [15:0] stk,
                                                  input logic [2:0] clicks);
        sosbtn_pkg::cfg_t c;
        c.debounce_ms     = deb;
        c.long_press_ms   = lng;
        c.click_window_ms = win;
        c.stuck_fault_ms  = stk;
        c.clicks_needed   = clicks;
        return c;
    endfunction

    // result side: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_stall     <= 0;
            hold_done    <= 1'b0;
        end
        else if (rx_stall != 0)
        begin
            rx_stall     <= rx_stall - 1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            rx_stall     <= HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
            hold_done    <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rx_stall     <= pick_gap();
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_sample(input logic p, input logic [31:0] t);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.pressed <= p;
        in_ch.now_ms  <= t;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic emit(input logic p, input logic [31:0] dt);
        clock_ms = clock_ms + dt;
        send_sample(p, clock_ms);
    endtask

    // stop offering and wait until no expected result is pending, then let the pipeline settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [15:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_config(input sosbtn_pkg::cfg_t c);
        put_reg(sosbtn_pkg::REG_DEBOUNCE, c.debounce_ms);
        put_reg(sosbtn_pkg::REG_LONG, c.long_press_ms);
        put_reg(sosbtn_pkg::REG_WINDOW, c.click_window_ms);
        put_reg(sosbtn_pkg::REG_STUCK, c.stuck_fault_ms);
        put_reg(sosbtn_pkg::REG_CLICKS, {13'd0, c.clicks_needed});
        // index past the register file is ignored
        put_reg(REG_UNUSED, 16'hFFFF);
        wr_en <= 1'b0;
    endtask

    // random sequences shaped around the current timing
    task automatic random_phase(input sosbtn_pkg::cfg_t c, input int unsigned n);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned k;
        int unsigned j;
        logic [31:0] deb_s;
        logic [31:0] long_s;
        logic [31:0] win_s;
        logic [31:0] stuck_s;
        stop_at = items_sent + n;
        deb_s   = c.debounce_ms;
        long_s  = c.long_press_ms;
        win_s   = c.click_window_ms;
        stuck_s = c.stuck_fault_ms;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            idle_on <= ($urandom_range(0, 3) != 0);
            if (kind < 55)
            begin
                // burst of quick presses
                k = $urandom_range(1, c.clicks_needed + 2);
                for (j = 0; j < k; j++)
                begin
                    emit(1'b1, $urandom_range(0, win_s / 8));
                    emit(1'b1, $urandom_range(deb_s / 2, deb_s * 2 + 1));
                    if ($urandom_range(0, 2) == 0)
                        emit(1'b1, $urandom_range(0, deb_s + 1));
                    emit(1'b0, $urandom_range(0, deb_s + 1));
                end
                emit(1'b0, $urandom_range(0, 1));
            end
            else if (kind < 80)
            begin
                // held press toward long press or stuck
                emit(1'b1, $urandom_range(0, win_s / 4));
                k = $urandom_range(2, 6);
                for (j = 0; j < k; j++)
                    emit(1'b1, $urandom_range(0, ((kind < 70) ? long_s : stuck_s) / 2 + 1));
                emit(1'b0, $urandom_range(0, 3));
            end
            else if (kind < 90)
            begin
                // released samples, window may lapse
                k = $urandom_range(1, 3);
                for (j = 0; j < k; j++)
                    emit(1'b0, $urandom_range(0, win_s + 2));
            end
            else
                emit(1'($urandom_range(0, 1)), $urandom());
        end
    endtask

    // stimulus
    initial
    begin
        in_ch.valid   <= 1'b0;
        in_ch.pressed <= 1'b0;
        in_ch.now_ms  <= '0;
        wr_en         <= 1'b0;
        wr_index      <= '0;
        wr_data       <= '0;
        idle_on       <= 1'b0;
        hold_req      <= 1'b0;
        rst_n         <= 1'b0;
        items_sent    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed at default timing, time wrapping through zero
        load_config(make_cfg(sosbtn_pkg::DEBOUNCE_RST, sosbtn_pkg::LONG_RST,
                             sosbtn_pkg::WINDOW_RST, sosbtn_pkg::STUCK_RST,
                             sosbtn_pkg::CLICKS_RST));
        clock_ms = 32'hFFFF_F000;
        // triple click gives a call
        emit(1'b1, 0);
        emit(1'b1, 60);
        emit(1'b0, 10);
        emit(1'b1, 10);
        emit(1'b1, 60);
        emit(1'b0, 10);
        emit(1'b1, 10);
        emit(1'b1, 60);
        emit(1'b1, 10);
        // long press released gives a call
        emit(1'b1, 100);
        emit(1'b1, 50);
        emit(1'b1, 2000);
        emit(1'b1, 100);
        emit(1'b0, 5);
        // held into the stuck fault, cleared on release
        emit(1'b1, 10);
        emit(1'b1, 60);
        emit(1'b1, 2000);
        emit(1'b1, 40000);
        emit(1'b1, 1);
        emit(1'b0, 1);
        // window lapses in count check, then idle clears the count
        emit(1'b1, 3);
        emit(1'b1, 60);
        emit(1'b0, 5000);
        emit(1'b0, 10);
        // press shorter than debounce
        emit(1'b1, 0);
        emit(1'b0, 10);
        drain();

        // short timing, with the long hold-off on the result side
        load_config(make_cfg(16'd5, 16'd100, 16'd400, 16'd300, 3'd3));
        clock_ms = $urandom();
        hold_req <= 1'b1;
        random_phase(make_cfg(16'd5, 16'd100, 16'd400, 16'd300, 3'd3), 75);
        drain();

        // single click, no debounce
        load_config(make_cfg(16'd0, 16'd20, 16'd60, 16'd50, 3'd1));
        random_phase(make_cfg(16'd0, 16'd20, 16'd60, 16'd50, 3'd1), 75);
        drain();

        // all zero: no press is ever counted
        load_config(make_cfg(16'd0, 16'd0, 16'd0, 16'd0, 3'd0));
        random_phase(make_cfg(16'd0, 16'd0, 16'd0, 16'd0, 3'd0), 50);
        drain();

        // all maximum, starting just before the time wraps
        load_config(make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7));
        clock_ms = 32'hFFFF_FF00;
        random_phase(make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7), 75);
        drain();

        // random moderate timing
        begin : rand_cfg_blk
            sosbtn_pkg::cfg_t c;
            c = make_cfg(16'($urandom_range(0, 20)), 16'($urandom_range(50, 200)),
                         16'($urandom_range(100, 1000)), 16'($urandom_range(100, 600)),
                         3'($urandom_range(1, 7)));
            load_config(c);
            clock_ms = $urandom();
            random_phase(c, 100);
        end
        drain();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
